[src/mst_pkg.sv]
// Shared types and constants for the monotone staircase table.
package mst_pkg;

  localparam logic signed [31:0] KeyMax = 32'sh7fffffff;

  typedef enum logic [2:0] {
    StInserted  = 3'd0,
    StDominated = 3'd1,
    StFull      = 3'd2,
    StQueryOk   = 3'd3,
    StQueryEnd  = 3'd4
  } status_e;

  typedef enum logic {
    ModeInsert = 1'b0,
    ModeQuery  = 1'b1
  } mode_e;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] item_key;
    logic signed [31:0] item_value;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] found_value;
  } result_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] value;
  } entry_t;

  typedef enum logic [3:0] {
    SIdle,
    SScanRd,
    SScanChk,
    SRunRd,
    SRunChk,
    SShRd,
    SShWr,
    SSetP,
    SDone,
    SClear
  } state_e;

endpackage

[src/mst_ram.sv]
// Generic single-port synchronous RAM with registered read.
module mst_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

[src/monotone_staircase_table.sv]
// Top level of the monotone staircase table: sequencer around the entry RAM.
//
//  channel   direction  handshake                  payload
//  item      in         start_i / busy_o           item_i (mst_pkg::item_t)
//  result    out        done_o strobe              result_o (mst_pkg::result_t)
//  config    in         cfg_valid_i / cfg_ready_o  boundary value, 32 bit signed
//
// A query reads and compares the entries in turn from slot 0, then passes
// through the done state before the strobe.
// An insert scans entries, reads the dominated run and moves tail entries,
// each with a read step and a check or write step, then writes the new pair.
// Reset or a config write passes through a clear state that writes the sentinel into slot 0,
// busy high. The next item is accepted in the strobe cycle; the receiver
// cannot stall results.
module monotone_staircase_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  mst_pkg::item_t    item_i,
  output logic              done_o,
  output mst_pkg::result_t  result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);
  import mst_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  state_e state_q, state_d;
  logic signed [31:0] bound_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] p_q, p_d;     // scan index / slot
  logic [CW-1:0] r_q, r_d;     // dominated run length
  logic [CW-1:0] i_q, i_d;     // shift index
  item_t it_q, it_d;
  logic same_q, same_d;
  result_t res_q, res_d;
  logic done_q, done_d;

  logic we;
  logic [AW-1:0] addr;
  entry_t wdata, rdata;

  mst_ram #(.Width(64), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // Shift distance: +1 for a new key with r==0 (shift up), else -r for the same key or 1-r for a new key (down).
  // Down shift moves entries from p+1 (same key) or p (new key) to cnt-1; the new pair then goes to p-r.
  logic up;
  assign up = !same_q && (r_q == '0);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; p_d = p_q; r_d = r_q; i_d = i_q; it_d = it_q;
    same_d = same_q; res_d = res_q; done_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          it_d = item_i; p_d = '0; state_d = SScanRd;
        end
      end
      SScanRd: state_d = SScanChk;
      SScanChk: begin
        if (it_q.mode == ModeQuery) begin
          if (rdata.key > it_q.item_key) begin
            res_d = '{StQueryOk, rdata.value}; state_d = SDone;
          end else if (p_q + 1'b1 >= cnt_q) begin
            res_d = '{StQueryEnd, 32'sd0}; state_d = SDone;
          end else begin
            p_d = p_q + 1'b1; state_d = SScanRd;
          end
        end else if (p_q + 1'b1 < cnt_q && rdata.key < it_q.item_key) begin
          p_d = p_q + 1'b1; state_d = SScanRd;
        end else if (!(rdata.value > it_q.item_value)) begin
          res_d = '{StDominated, 32'sd0}; state_d = SDone;
        end else begin
          same_d = (rdata.key == it_q.item_key);
          if (rdata.key != it_q.item_key && cnt_q >= DepthC) begin
            res_d = '{StFull, 32'sd0}; state_d = SDone;
          end else begin
            res_d = '{StInserted, 32'sd0};
            r_d = '0;
            state_d = (p_q == '0) ? SShRd : SRunRd;
          end
        end
      end
      SRunRd: state_d = SRunChk;
      SRunChk: begin
        if (rdata.value >= it_q.item_value) begin
          r_d = r_q + 1'b1;
          state_d = (r_q + 1'b1 == p_q) ? SShRd : SRunRd;
        end else begin
          state_d = SShRd;
        end
      end
      SShRd: begin
        // start index of tail copy
        if (same_q && r_q == '0) state_d = SSetP;
        else begin
          i_d = up ? cnt_q - 1'b1 : p_q + (same_q ? 1'b1 : 1'b0);
          state_d = SShWr;
          if (!up && !same_q) i_d = p_q;
          if (!up && i_d >= cnt_q) state_d = SSetP;
        end
      end
      SShWr: begin
        // read/write phases and exit handled by the shift engine below
        state_d = SShWr;
      end
      SSetP: begin
        if (!same_q) cnt_d = up ? cnt_q + 1'b1 : cnt_q + 1'b1 - r_q;
        else cnt_d = cnt_q - r_q;
        state_d = SDone;
      end
      SDone: begin
        done_d = 1'b1; state_d = SIdle;
      end
      SClear: begin
        state_d = SIdle; cnt_d = CW'(1);
      end
      default: state_d = SIdle;
    endcase
    if (state_q == SIdle && cfg_valid_i) begin
      state_d = SClear;
    end
  end

  // Shift engine: alternate read (ph=0) and write (ph=1).
  logic ph_q;
  logic [CW-1:0] cnt_eff;
  assign cnt_eff = cnt_q;

  logic sh_last;
  always_comb begin
    if (up) sh_last = (i_q == p_q);
    else    sh_last = (i_q + 1'b1 >= cnt_eff);
  end

  state_e st_n;
  logic [CW-1:0] i_n;
  always_comb begin
    st_n = state_d; i_n = i_d;
    if (state_q == SShWr && ph_q) begin
      if (sh_last) st_n = SSetP;
      else i_n = up ? i_q - 1'b1 : i_q + 1'b1;
    end
  end

  always_comb begin
    we = 1'b0; addr = p_q[AW-1:0]; wdata = '{it_q.item_key, it_q.item_value};
    case (state_q)
      SRunRd: addr = AW'(p_q - 1'b1 - r_q);
      SShWr: begin
        if (!ph_q) addr = i_q[AW-1:0];
        else begin
          we = 1'b1; wdata = rdata;
          addr = up ? AW'(i_q + 1'b1)
                    : AW'(i_q - r_q + (same_q ? 1'b0 : 1'b1));
        end
      end
      SSetP: begin
        we = 1'b1; addr = AW'(p_q - r_q);
      end
      SClear: begin
        we = 1'b1; addr = '0; wdata = '{KeyMax, bound_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; bound_q <= '0; cnt_q <= CW'(1);
      p_q <= '0; r_q <= '0; i_q <= '0; same_q <= 1'b0; done_q <= 1'b0;
      ph_q <= 1'b0; it_q <= '0; res_q <= '0;
    end else begin
      state_q <= st_n; cnt_q <= cnt_d; p_q <= p_d; r_q <= r_d; i_q <= i_n;
      same_q <= same_d; done_q <= done_d; it_q <= it_d; res_q <= res_d;
      ph_q <= (state_q == SShWr) ? !ph_q : 1'b0;
      if (state_q == SIdle && cfg_valid_i) bound_q <= cfg_data_i;
    end
  end

  assign busy_o = (state_q != SIdle) || cfg_valid_i;
  assign cfg_ready_o = (state_q == SIdle);
  assign done_o = done_q;
  assign result_o = res_q;

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("double result");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= CW'(1)) && (cnt_q <= DepthC)) else $error("count out of range");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == SIdle) else $error("result outside idle");
endmodule
